>>> hw/rtl/sorted_insert_priority_queue_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted queue check failed");

// ante implies cons in the next cycle
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted queue check failed");

`endif

>>> hw/rtl/spq_pkg.sv
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CAP_W     = 5;
	localparam int LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic       REQ_INSERT   = 1'b0;
	localparam logic       REQ_REMOVE   = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [KEY_WIDTH-1:0] wdata;
		logic                 re;
		logic [ADDR_W-1:0]    raddr;
	} ram_req_t;

endpackage

>>> hw/rtl/spq_key_ram.sv
module spq_key_ram
	import spq_pkg::*;
(
	input  logic                 clk,
	input  ram_req_t             req,
	output logic [KEY_WIDTH-1:0] rd_data
);

	logic [KEY_WIDTH-1:0] mem [DEPTH];
	logic [KEY_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/spq_ctrl.sv
module spq_ctrl
	import spq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        req_type,
	input  logic signed [KEY_WIDTH-1:0] key_value,
	input  logic        [CNT_W-1:0]     limit,
	output logic                        busy,
	output logic                        done,
	output logic signed [KEY_WIDTH-1:0] removed_key,
	output logic        [1:0]           status,
	output logic        [CNT_W-1:0]     entry_count,
	output ram_req_t                    ram_req,
	input  logic        [KEY_WIDTH-1:0] ram_rdata
);

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_INS       = 5'b00010,
		ST_INS_LAST  = 5'b00100,
		ST_REM_HEAD  = 5'b01000,
		ST_REM_SHIFT = 5'b10000
	} spq_state_t;

	spq_state_t                  state_q, state_d;
	logic        [CNT_W-1:0]     count_q, count_d;
	logic        [ADDR_W-1:0]    idx_q, idx_d;
	logic signed [KEY_WIDTH-1:0] key_q, key_d;
	logic                        done_q, done_d;
	logic signed [KEY_WIDTH-1:0] removed_q, removed_d;
	logic        [1:0]           status_q, status_d;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		key_d     = key_q;
		done_d    = 1'b0;
		removed_d = removed_q;
		status_d  = status_q;
		ram_req   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_INSERT) begin
						if (count_q >= limit) begin
							done_d    = 1'b1;
							status_d  = STATUS_FULL;
							removed_d = '0;
						end else if (count_q == '0) begin
							ram_req.we    = 1'b1;
							ram_req.waddr = '0;
							ram_req.wdata = key_value;
							count_d       = CNT_W'(1);
							done_d        = 1'b1;
							status_d      = STATUS_OK;
							removed_d     = '0;
						end else begin
							key_d         = key_value;
							ram_req.re    = 1'b1;
							ram_req.raddr = ADDR_W'(count_q - CNT_W'(1));
							idx_d         = ADDR_W'(count_q - CNT_W'(1));
							state_d       = ST_INS;
						end
					end else begin
						if (count_q == '0) begin
							done_d    = 1'b1;
							status_d  = STATUS_EMPTY;
							removed_d = '0;
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = '0;
							state_d       = ST_REM_HEAD;
						end
					end
				end
			end
			ST_INS: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q + ADDR_W'(1);
				if ($signed(ram_rdata) > key_q) begin
					ram_req.wdata = ram_rdata;
					if (idx_q == '0) begin
						state_d = ST_INS_LAST;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = idx_q - ADDR_W'(1);
						idx_d         = idx_q - ADDR_W'(1);
					end
				end else begin
					ram_req.wdata = key_q;
					count_d       = count_q + CNT_W'(1);
					done_d        = 1'b1;
					status_d      = STATUS_OK;
					removed_d     = '0;
					state_d       = ST_IDLE;
				end
			end
			ST_INS_LAST: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = '0;
				ram_req.wdata = key_q;
				count_d       = count_q + CNT_W'(1);
				done_d        = 1'b1;
				status_d      = STATUS_OK;
				removed_d     = '0;
				state_d       = ST_IDLE;
			end
			ST_REM_HEAD: begin
				done_d    = 1'b1;
				status_d  = STATUS_OK;
				removed_d = ram_rdata;
				count_d   = count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ADDR_W'(1);
					idx_d         = ADDR_W'(1);
					state_d       = ST_REM_SHIFT;
				end
			end
			ST_REM_SHIFT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q - ADDR_W'(1);
				ram_req.wdata = ram_rdata;
				if (CNT_W'(idx_q) == count_q) begin
					state_d = ST_IDLE;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = idx_q + ADDR_W'(1);
					idx_d         = idx_q + ADDR_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		key_q     <= key_d;
		removed_q <= removed_d;
		status_q  <= status_d;
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign removed_key = removed_q;
	assign status      = status_q;
	assign entry_count = count_q;

endmodule

>>> hw/rtl/sorted_insert_priority_queue_core.sv
// Sorted priority queue of signed keys held in one single-port-read, single-port-write
// key memory. An item is taken when start is high and busy is low; its result appears
// on removed_key, status and entry_count for one cycle with done high, and must be
// captured then, as it cannot be held off. A dropped insert (queue full) or a remove
// from an empty queue is answered from the idle state and a new item may follow at once.
// An insert into an empty queue is also answered from the idle state. Any other insert
// walks the memory from the top entry down, one entry per cycle, moving larger keys up,
// and then writes the new key above the first key that is not larger, or at entry 0
// when it becomes the smallest. A remove reads the head and then moves the other n - 1
// keys down one entry per cycle for n stored keys; its result shows after the head read
// while the move-down still runs. The one memory read port sets this pace. Write
// capacity_limit through cfg_we and cfg_wdata only while idle.
module sorted_insert_priority_queue_core
	import spq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic        [CAP_W-1:0]     cfg_wdata,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic signed [KEY_WIDTH-1:0] key_value,
	output logic                        done,
	output logic signed [KEY_WIDTH-1:0] removed_key,
	output logic        [1:0]           status,
	output logic        [CNT_W-1:0]     entry_count
);

	logic [CAP_W-1:0]     cap_q;
	logic [LIM_W-1:0]     cap_ext;
	logic [LIM_W-1:0]     depth_ext;
	logic [CNT_W-1:0]     limit;
	ram_req_t             ram_req;
	logic [KEY_WIDTH-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(DEPTH);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_comb begin
		cap_ext   = LIM_W'(cap_q);
		depth_ext = LIM_W'(DEPTH);
		if (cap_ext > depth_ext) begin
			limit = CNT_W'(depth_ext);
		end else begin
			limit = CNT_W'(cap_ext);
		end
	end

	spq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.key_value   (key_value),
		.limit       (limit),
		.busy        (busy),
		.done        (done),
		.removed_key (removed_key),
		.status      (status),
		.entry_count (entry_count),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata)
	);

	spq_key_ram u_key_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rdata)
	);

endmodule

>>> hw/rtl/spq_checker.sv
`include "sorted_insert_priority_queue_core_assert.svh"

module spq_checker
	import spq_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        done,
	input logic signed [KEY_WIDTH-1:0] removed_key,
	input logic        [1:0]           status,
	input logic        [CNT_W-1:0]     entry_count
);

	`SPQ_ASSERT_IMPLY(a_count_bound, clk, arst_n, done, entry_count <= CNT_W'(DEPTH))
	`SPQ_ASSERT_IMPLY(a_flag_zero_key, clk, arst_n, done && status != STATUS_OK, removed_key == '0)
	`SPQ_ASSERT_IMPLY(a_empty_count, clk, arst_n, done && status == STATUS_EMPTY, entry_count == '0)
	`SPQ_ASSERT_IMPLY(a_full_hold, clk, arst_n, done && status == STATUS_FULL, entry_count == $past(entry_count))

endmodule

bind sorted_insert_priority_queue_core spq_checker u_spq_checker (.*);
